@@ src/swcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// swcrc_pkg
// Shared types, constants and crc-32 helpers for the stop-and-wait receiver.
// ----------------------------------------------------------------------------
package swcrc_pkg;

  localparam int unsigned HEADER_LEN = 16;
  localparam int unsigned IDX_W      = 11;

  localparam logic [31:0]      CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0]      ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0]      FIN_TYPE  = 32'd2;
  localparam logic [IDX_W-1:0] INDEX_MAX = 11'd2047;

  // header word positions, byte_index[3:2]
  localparam logic [1:0] WORD_TYPE = 2'd0;
  localparam logic [1:0] WORD_SEQ  = 2'd1;
  localparam logic [1:0] WORD_LEN  = 2'd2;
  localparam logic [1:0] WORD_CRC  = 2'd3;

  typedef enum logic [1:0] {
    ST_CORRUPT = 2'd0,
    ST_COMMIT  = 2'd1,
    ST_DUP     = 2'd2,
    ST_FIN     = 2'd3
  } status_e;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        verdict_valid;
    logic [1:0]  status;
    logic        ack_valid;
    logic [31:0] ack_seq;
    logic [31:0] ack_checksum;
    logic        finished;
  } result_t;

  // request from the parser to the ack crc generator
  typedef struct packed {
    logic        commit;
    logic [31:0] next_seq;
  } ack_req_t;

  // ack crc values for the two sequence numbers that can be acknowledged
  typedef struct packed {
    logic [31:0] exp_crc;
    logic [31:0] acked_crc;
  } ack_crc_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_word_le(logic [31:0] crc, logic [31:0] w);
    logic [31:0] c;
    c = crc;
    for (int j = 0; j < 4; j++) begin
      c = crc_byte(c, w[8*j +: 8]);
    end
    return c;
  endfunction

  function automatic logic [31:0] ack_crc_fn(logic [31:0] seq);
    logic [31:0] c;
    c = crc_word_le(ALL_ONES, 32'd0);
    c = crc_word_le(c, seq);
    c = crc_word_le(c, 32'(HEADER_LEN));
    return ~c;
  endfunction

  // crc state after the ack type word, which is always zero
  localparam logic [31:0] CRC_AFTER_TYPE = crc_word_le(ALL_ONES, 32'd0);
  // ack checksum for sequence zero, the value after reset
  localparam logic [31:0] ACK_CRC_SEQ0   = ack_crc_fn(32'd0);

endpackage

@@ src/swcrc_ack_gen.sv @@
// ----------------------------------------------------------------------------
// swcrc_ack_gen
// Keeps the ack checksums for the expected and the last acked sequence,
// recomputing the expected one a byte per cycle after each commit.
// ----------------------------------------------------------------------------
module swcrc_ack_gen (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swcrc_pkg::ack_req_t req_i,
  output swcrc_pkg::ack_crc_t crc_o
);

  logic        busy_q, busy_d;
  logic [2:0]  step_q, step_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] run_q, run_d;
  logic [31:0] exp_crc_q, exp_crc_d;
  logic [31:0] acked_crc_q, acked_crc_d;
  logic [7:0]  feed_byte;
  logic [31:0] run_next;

  // sequence bytes first (lsb first), then the length word 16
  always_comb begin
    if (!step_q[2]) begin
      feed_byte = seq_q[{step_q[1:0], 3'b000} +: 8];
    end else if (step_q[1:0] == 2'd0) begin
      feed_byte = 8'(swcrc_pkg::HEADER_LEN);
    end else begin
      feed_byte = 8'd0;
    end
  end

  assign run_next = swcrc_pkg::crc_byte(run_q, feed_byte);

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    seq_d       = seq_q;
    run_d       = run_q;
    exp_crc_d   = exp_crc_q;
    acked_crc_d = acked_crc_q;
    if (req_i.commit) begin
      acked_crc_d = exp_crc_q;
      seq_d       = req_i.next_seq;
      run_d       = swcrc_pkg::CRC_AFTER_TYPE;
      step_d      = 3'd0;
      busy_d      = 1'b1;
    end else if (busy_q) begin
      run_d  = run_next;
      step_d = step_q + 3'd1;
      if (step_q == 3'd7) begin
        exp_crc_d = ~run_next;
        busy_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= 3'd0;
      exp_crc_q   <= swcrc_pkg::ACK_CRC_SEQ0;
      acked_crc_q <= swcrc_pkg::ACK_CRC_SEQ0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      exp_crc_q   <= exp_crc_d;
      acked_crc_q <= acked_crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    run_q <= run_d;
  end

  assign crc_o.exp_crc   = exp_crc_q;
  assign crc_o.acked_crc = acked_crc_q;

endmodule

@@ src/swcrc_core.sv @@
// ----------------------------------------------------------------------------
// swcrc_core
// Per-byte datagram parser: header capture, crc check, data release and
// the end-of-datagram verdict.
// ----------------------------------------------------------------------------
module swcrc_core #(
  parameter int unsigned MAX_DATAGRAM = 1472
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 last_byte_i,
  input  swcrc_pkg::ack_crc_t  ack_crc_i,
  output swcrc_pkg::ack_req_t  ack_req_o,
  output logic                 res_valid_o,
  output swcrc_pkg::result_t   res_o
);

  localparam int unsigned IW = swcrc_pkg::IDX_W;
  localparam logic [IW-1:0] MAX_DATA = IW'(MAX_DATAGRAM - swcrc_pkg::HEADER_LEN);
  localparam logic [IW-1:0] HDR_LEN  = IW'(swcrc_pkg::HEADER_LEN);
  localparam logic [31:0]   HDR_LEN32 = 32'(swcrc_pkg::HEADER_LEN);
  localparam logic [31:0]   MAX_DG32  = 32'(MAX_DATAGRAM);

  logic [IW-1:0] idx_q, idx_d;
  logic [31:0]   word_q, word_d;
  logic [31:0]   type_q, type_d;
  logic [31:0]   seq_q, seq_d;
  logic [31:0]   len_q, len_d;
  logic [31:0]   rxcrc_q, rxcrc_d;
  logic [31:0]   crc_q, crc_d;
  logic [IW-1:0] rem_q, rem_d;
  logic [31:0]   exp_seq_q, exp_seq_d;
  logic [31:0]   acked_seq_q, acked_seq_d;
  logic          done_q, done_d;

  logic          in_hdr;
  logic [31:0]   hdr_word;
  logic [7:0]    crc_src;
  logic          crc_en;
  logic [31:0]   crc_upd;
  logic          pkt_ok;
  swcrc_pkg::result_t res;

  assign in_hdr = (idx_q < HDR_LEN);

  // header words enter the crc one word late, while the next word arrives, lsb first
  always_comb begin
    case (idx_q[3:2])
      swcrc_pkg::WORD_SEQ:  hdr_word = type_q;
      swcrc_pkg::WORD_LEN:  hdr_word = seq_q;
      swcrc_pkg::WORD_CRC:  hdr_word = len_q;
      default:              hdr_word = 32'd0;
    endcase
  end

  always_comb begin
    if (in_hdr) begin
      crc_src = hdr_word[{idx_q[1:0], 3'b000} +: 8];
      crc_en  = (idx_q[3:2] != swcrc_pkg::WORD_TYPE);
    end else begin
      crc_src = rx_byte_i;
      crc_en  = (rem_q != '0);
    end
  end

  assign crc_upd = swcrc_pkg::crc_byte(crc_q, crc_src);

  always_comb begin
    idx_d       = idx_q;
    word_d      = word_q;
    type_d      = type_q;
    seq_d       = seq_q;
    len_d       = len_q;
    rxcrc_d     = rxcrc_q;
    crc_d       = crc_en ? crc_upd : crc_q;
    rem_d       = rem_q;
    exp_seq_d   = exp_seq_q;
    acked_seq_d = acked_seq_q;
    done_d      = done_q;
    pkt_ok      = 1'b0;
    ack_req_o   = '0;
    res         = '0;

    if (in_hdr) begin
      word_d = {word_q[23:0], rx_byte_i};
      if (idx_q[1:0] == 2'd3) begin
        case (idx_q[3:2])
          swcrc_pkg::WORD_TYPE: type_d = word_d;
          swcrc_pkg::WORD_SEQ:  seq_d  = word_d;
          swcrc_pkg::WORD_LEN: begin
            len_d = word_d;
            if (word_d < HDR_LEN32) begin
              rem_d = '0;
            end else if (word_d > MAX_DG32) begin
              rem_d = MAX_DATA;
            end else begin
              rem_d = word_d[IW-1:0] - HDR_LEN;
            end
          end
          default:              rxcrc_d = word_d;
        endcase
      end
    end else if (rem_q != '0) begin
      rem_d          = rem_q - IW'(1);
      res.data_valid = 1'b1;
      res.data_byte  = rx_byte_i;
    end

    if (last_byte_i) begin
      pkt_ok = (idx_q >= HDR_LEN - IW'(1)) && (len_q >= HDR_LEN32) &&
               (rem_d == '0) && (~crc_d == rxcrc_d);
      res.verdict_valid = 1'b1;
      if (!pkt_ok) begin
        res.status = swcrc_pkg::ST_CORRUPT;
      end else if (seq_q == exp_seq_q) begin
        res.ack_valid    = 1'b1;
        res.ack_seq      = exp_seq_q;
        res.ack_checksum = ack_crc_i.exp_crc;
        if (type_q == swcrc_pkg::FIN_TYPE) begin
          res.status = swcrc_pkg::ST_FIN;
          done_d     = 1'b1;
        end else begin
          res.status         = swcrc_pkg::ST_COMMIT;
          acked_seq_d        = exp_seq_q;
          exp_seq_d          = exp_seq_q + 32'd1;
          ack_req_o.commit   = step_i;
          ack_req_o.next_seq = exp_seq_q + 32'd1;
        end
      end else begin
        res.status       = swcrc_pkg::ST_DUP;
        res.ack_valid    = 1'b1;
        res.ack_seq      = acked_seq_q;
        res.ack_checksum = ack_crc_i.acked_crc;
      end
      idx_d  = '0;
      word_d = '0;
      crc_d  = swcrc_pkg::ALL_ONES;
      rem_d  = '0;
    end else if (idx_q < swcrc_pkg::INDEX_MAX) begin
      idx_d = idx_q + IW'(1);
    end

    res.finished = done_d;

    // after the fin everything is ignored
    if (done_q) begin
      ack_req_o = '0;
    end
  end

  assign res_valid_o = step_i && !done_q && (res.data_valid || res.verdict_valid);
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      word_q      <= '0;
      type_q      <= '0;
      seq_q       <= '0;
      len_q       <= '0;
      rxcrc_q     <= '0;
      crc_q       <= swcrc_pkg::ALL_ONES;
      rem_q       <= '0;
      exp_seq_q   <= '0;
      acked_seq_q <= '0;
      done_q      <= 1'b0;
    end else if (step_i && !done_q) begin
      idx_q       <= idx_d;
      word_q      <= word_d;
      type_q      <= type_d;
      seq_q       <= seq_d;
      len_q       <= len_d;
      rxcrc_q     <= rxcrc_d;
      crc_q       <= crc_d;
      rem_q       <= rem_d;
      exp_seq_q   <= exp_seq_d;
      acked_seq_q <= acked_seq_d;
      done_q      <= done_d;
    end
  end

endmodule

@@ src/swcrc_out_queue.sv @@
// ----------------------------------------------------------------------------
// swcrc_out_queue
// Two-entry result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module swcrc_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  swcrc_pkg::result_t push_data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output swcrc_pkg::result_t data_o
);

  swcrc_pkg::result_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/stop_and_wait_crc_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_crc_receiver_unit
// Stop-and-wait receiver: parses datagrams a byte at a time, checks crc-32,
// releases payload tentatively and gives a verdict with an optional ack.
// ----------------------------------------------------------------------------
// usage
//   input channel: one request per datagram byte (rx_byte_i, last_byte_i),
//     taken when in_valid_i is high and in_stall_o is low
//   output channel: one request per payload byte or per datagram end,
//     taken when out_valid_o is high and out_stall_i is low; bytes that
//     are past the declared length or before the header end give nothing
//   throughput: one byte per cycle while the queue has room; the crc unit
//     folds one byte per step, header words a byte at a time while the
//     next word arrives
//   path: input register, then parse into the two-entry result queue,
//     whose head drives the output
//   when the receiver stalls, the queue fills; with the queue full the
//     input register holds its byte and in_stall_o goes high
//   the ack checksum for the next expected sequence is rebuilt a byte at
//     a time after each commit, well before the next datagram can end
//   reset clears all sequence state, empties the queue and clears finished;
//     after an in-order fin every further byte is dropped until reset
// ----------------------------------------------------------------------------
module stop_and_wait_crc_receiver_unit #(
  parameter int unsigned MAX_DATAGRAM = 1472
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        last_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        verdict_valid_o,
  output logic [1:0]  status_o,
  output logic        ack_valid_o,
  output logic [31:0] ack_seq_o,
  output logic [31:0] ack_checksum_o,
  output logic        finished_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  logic                accept;
  logic                step;
  logic                q_full;
  logic                res_valid;
  swcrc_pkg::result_t  res;
  swcrc_pkg::result_t  out_res;
  swcrc_pkg::ack_req_t ack_req;
  swcrc_pkg::ack_crc_t ack_crc;

  // the held byte is parsed whenever the queue has room for its result
  assign step       = s1_valid_q && !q_full;
  assign in_stall_o = s1_valid_q && q_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= rx_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  swcrc_core #(
    .MAX_DATAGRAM (MAX_DATAGRAM)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (s1_byte_q),
    .last_byte_i (s1_last_q),
    .ack_crc_i   (ack_crc),
    .ack_req_o   (ack_req),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // keeps ack checksums ready for both possible ack sequences
  swcrc_ack_gen u_ack_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ack_req),
    .crc_o  (ack_crc)
  );

  swcrc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (q_full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_res)
  );

  assign data_valid_o    = out_res.data_valid;
  assign data_byte_o     = out_res.data_byte;
  assign verdict_valid_o = out_res.verdict_valid;
  assign status_o        = out_res.status;
  assign ack_valid_o     = out_res.ack_valid;
  assign ack_seq_o       = out_res.ack_seq;
  assign ack_checksum_o  = out_res.ack_checksum;
  assign finished_o      = out_res.finished;

endmodule
